// ===== hdl/rbb_pkg.sv =====
// ----------------------------------------------------------------------------
// rbb_pkg
// shared types and fixed widths for the rotated box bounds pipeline
// ----------------------------------------------------------------------------
package rbb_pkg;

    // coordinate width (signed q16.16) and quaternion component width
    localparam int COORD_W = 32;
    localparam int QUAT_W  = 16;

    // input item: axis-aligned box and rotation quaternion
    typedef struct packed {
        logic signed [COORD_W-1:0] box_min_x;
        logic signed [COORD_W-1:0] box_max_x;
        logic signed [COORD_W-1:0] box_min_y;
        logic signed [COORD_W-1:0] box_max_y;
        logic signed [COORD_W-1:0] box_min_z;
        logic signed [COORD_W-1:0] box_max_z;
        logic signed [QUAT_W-1:0]  quat_w;
        logic signed [QUAT_W-1:0]  quat_x;
        logic signed [QUAT_W-1:0]  quat_y;
        logic signed [QUAT_W-1:0]  quat_z;
    } box_item_t;

    // result item: bounds of the rotated box
    typedef struct packed {
        logic signed [COORD_W-1:0] out_min_x;
        logic signed [COORD_W-1:0] out_max_x;
        logic signed [COORD_W-1:0] out_min_y;
        logic signed [COORD_W-1:0] out_max_y;
        logic signed [COORD_W-1:0] out_min_z;
        logic signed [COORD_W-1:0] out_max_z;
    } bounds_item_t;

endpackage

// ===== hdl/rotated_box_bounds.sv =====
// done follows the accepting edge through the valid registers v1_reg to v5_reg and done_reg
// throughput: one item per cycle, busy stays low, no stall is ever needed
// six register stages: quaternion products, matrix, split multipliers,
// per-term min/max, three-term sums, shift and saturate
// reset: asynchronous active-low clears the valid bits; payload is not reset
// ----------------------------------------------------------------------------
// rotated_box_bounds
// rotates an axis-aligned box by a unit quaternion and returns the new box
// ----------------------------------------------------------------------------
module rotated_box_bounds #(
    parameter int QUAT_FRAC_BITS = 14
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  rbb_pkg::box_item_t    box,
    output logic                 done,
    output rbb_pkg::bounds_item_t bounds
);
    import rbb_pkg::*;

    // matrix entries carry 2*QUAT_FRAC_BITS fraction bits
    localparam int QF2 = 2 * QUAT_FRAC_BITS;
    // matrix entry width: covers 1.0 and the +-2^32 range of 2*(ab +- cd)
    localparam int MW  = (QF2 + 2 > 35) ? QF2 + 2 : 35;
    // each entry is multiplied in two halves to keep the multipliers narrow
    localparam int MH  = MW / 2;
    localparam int ML  = MW - MH;
    localparam int PHW = MH + COORD_W;
    localparam int PLW = ML + 1 + COORD_W;
    // full product and three-term sum widths
    localparam int PRW = MW + COORD_W;
    localparam int SW  = PRW + 2;
    localparam int PW  = 2 * QUAT_W;

    localparam logic signed [MW-1:0] ONE = {{(MW-1){1'b0}}, 1'b1} << QF2;

    // the pipeline never needs to hold off the sender
    assign busy = 1'b0;

    logic accept;
    assign accept = start & ~busy;

    // ------------------------------------------------------------------
    // valid bits travel alongside the data
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= accept;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            v5_reg   <= v4_reg;
            done_reg <= v5_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: the nine quaternion component products
    // ------------------------------------------------------------------
    logic signed [PW-1:0] qxx_next, qyy_next, qzz_next, qxy_next, qxz_next;
    logic signed [PW-1:0] qyz_next, qwx_next, qwy_next, qwz_next;
    logic signed [PW-1:0] qxx_reg, qyy_reg, qzz_reg, qxy_reg, qxz_reg;
    logic signed [PW-1:0] qyz_reg, qwx_reg, qwy_reg, qwz_reg;
    box_item_t            box1_reg;

    always_comb
    begin
        qxx_next = box.quat_x * box.quat_x;
        qyy_next = box.quat_y * box.quat_y;
        qzz_next = box.quat_z * box.quat_z;
        qxy_next = box.quat_x * box.quat_y;
        qxz_next = box.quat_x * box.quat_z;
        qyz_next = box.quat_y * box.quat_z;
        qwx_next = box.quat_w * box.quat_x;
        qwy_next = box.quat_w * box.quat_y;
        qwz_next = box.quat_w * box.quat_z;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            qxx_reg  <= qxx_next;
            qyy_reg  <= qyy_next;
            qzz_reg  <= qzz_next;
            qxy_reg  <= qxy_next;
            qxz_reg  <= qxz_next;
            qyz_reg  <= qyz_next;
            qwx_reg  <= qwx_next;
            qwy_reg  <= qwy_next;
            qwz_reg  <= qwz_next;
            box1_reg <= box;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: standard rotation matrix, diagonal 1 - 2(b^2 + c^2),
    // off-diagonal 2(ab +- wc)
    // ------------------------------------------------------------------
    logic signed [MW-1:0] m_next [3][3];
    logic signed [MW-1:0] m_reg  [3][3];
    box_item_t            box2_reg;

    always_comb
    begin
        m_next[0][0] = ONE - ((MW'(qyy_reg) + MW'(qzz_reg)) <<< 1);
        m_next[0][1] = (MW'(qxy_reg) - MW'(qwz_reg)) <<< 1;
        m_next[0][2] = (MW'(qxz_reg) + MW'(qwy_reg)) <<< 1;
        m_next[1][0] = (MW'(qxy_reg) + MW'(qwz_reg)) <<< 1;
        m_next[1][1] = ONE - ((MW'(qxx_reg) + MW'(qzz_reg)) <<< 1);
        m_next[1][2] = (MW'(qyz_reg) - MW'(qwx_reg)) <<< 1;
        m_next[2][0] = (MW'(qxz_reg) - MW'(qwy_reg)) <<< 1;
        m_next[2][1] = (MW'(qyz_reg) + MW'(qwx_reg)) <<< 1;
        m_next[2][2] = ONE - ((MW'(qxx_reg) + MW'(qyy_reg)) <<< 1);
    end

    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            m_reg    <= m_next;
            box2_reg <= box1_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: each matrix entry times the lower and the upper bound of
    // its column axis, split into a signed high half and an unsigned low
    // half; the rotated coordinate is linear in each axis, so the corner
    // extremes come from per-term extremes (18 products, not 72)
    // ------------------------------------------------------------------
    logic signed [COORD_W-1:0] c2 [3][2];
    logic signed [PHW-1:0]     ph_next [3][3][2];
    logic signed [PLW-1:0]     pl_next [3][3][2];
    logic signed [PHW-1:0]     ph_reg  [3][3][2];
    logic signed [PLW-1:0]     pl_reg  [3][3][2];

    always_comb
    begin
        c2[0][0] = box2_reg.box_min_x;
        c2[0][1] = box2_reg.box_max_x;
        c2[1][0] = box2_reg.box_min_y;
        c2[1][1] = box2_reg.box_max_y;
        c2[2][0] = box2_reg.box_min_z;
        c2[2][1] = box2_reg.box_max_z;
        for (int a = 0; a < 3; a++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                for (int b = 0; b < 2; b++)
                begin
                    ph_next[a][j][b] = $signed(m_reg[a][j][MW-1:ML]) * c2[j][b];
                    pl_next[a][j][b] = $signed({1'b0, m_reg[a][j][ML-1:0]}) * c2[j][b];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (v2_reg)
        begin
            ph_reg <= ph_next;
            pl_reg <= pl_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: rebuild the full products, keep the smaller and the larger
    // of each bound pair
    // ------------------------------------------------------------------
    logic signed [PRW-1:0] tlo_next [3][3];
    logic signed [PRW-1:0] thi_next [3][3];
    logic signed [PRW-1:0] tlo_reg  [3][3];
    logic signed [PRW-1:0] thi_reg  [3][3];

    always_comb
    begin
        logic signed [PRW-1:0] p_lo;
        logic signed [PRW-1:0] p_hi;
        for (int a = 0; a < 3; a++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                p_lo = (PRW'(ph_reg[a][j][0]) <<< ML) + PRW'(pl_reg[a][j][0]);
                p_hi = (PRW'(ph_reg[a][j][1]) <<< ML) + PRW'(pl_reg[a][j][1]);
                if (p_lo < p_hi)
                begin
                    tlo_next[a][j] = p_lo;
                    thi_next[a][j] = p_hi;
                end
                else
                begin
                    tlo_next[a][j] = p_hi;
                    thi_next[a][j] = p_lo;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (v3_reg)
        begin
            tlo_reg <= tlo_next;
            thi_reg <= thi_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 5: three-term sums give the extreme rotated coordinates
    // ------------------------------------------------------------------
    logic signed [SW-1:0] slo_next [3];
    logic signed [SW-1:0] shi_next [3];
    logic signed [SW-1:0] slo_reg  [3];
    logic signed [SW-1:0] shi_reg  [3];

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            slo_next[a] = SW'(tlo_reg[a][0]) + SW'(tlo_reg[a][1]) + SW'(tlo_reg[a][2]);
            shi_next[a] = SW'(thi_reg[a][0]) + SW'(thi_reg[a][1]) + SW'(thi_reg[a][2]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (v4_reg)
        begin
            slo_reg <= slo_next;
            shi_reg <= shi_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 6: truncate toward minus infinity, saturate to the coordinate
    // range; both steps are monotonic, so they commute with min and max
    // ------------------------------------------------------------------
    logic signed [COORD_W-1:0] rlo [3];
    logic signed [COORD_W-1:0] rhi [3];
    bounds_item_t              bounds_next;
    bounds_item_t              bounds_reg;

    always_comb
    begin
        logic signed [SW-1:0] t;
        for (int a = 0; a < 3; a++)
        begin
            t = slo_reg[a] >>> QF2;
            if (t[SW-1:COORD_W-1] == {(SW-COORD_W+1){t[SW-1]}})
                rlo[a] = t[COORD_W-1:0];
            else
                rlo[a] = {t[SW-1], {(COORD_W-1){~t[SW-1]}}};
            t = shi_reg[a] >>> QF2;
            if (t[SW-1:COORD_W-1] == {(SW-COORD_W+1){t[SW-1]}})
                rhi[a] = t[COORD_W-1:0];
            else
                rhi[a] = {t[SW-1], {(COORD_W-1){~t[SW-1]}}};
        end
        bounds_next.out_min_x = rlo[0];
        bounds_next.out_max_x = rhi[0];
        bounds_next.out_min_y = rlo[1];
        bounds_next.out_max_y = rhi[1];
        bounds_next.out_min_z = rlo[2];
        bounds_next.out_max_z = rhi[2];
    end

    always_ff @(posedge clk)
    begin
        if (v5_reg)
        begin
            bounds_reg <= bounds_next;
        end
    end

    // result shows for one cycle with done, the receiver takes it then
    assign done   = done_reg;
    assign bounds = bounds_reg;

endmodule

// ===== hdl/rbb_checker.sv =====
// ----------------------------------------------------------------------------
// rbb_checker
// port-level checks on the rotated box bounds handshake and latency
// ----------------------------------------------------------------------------
module rbb_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);
    localparam int LATENCY = 6;

    // the pipeline takes an item in every cycle
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised by a stall-free pipeline");

    // every accepted item comes out after the fixed latency
    a_item_out: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("accepted item did not come out on time");

    // no result without an item accepted the latency earlier
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without a matching accepted item");

endmodule

bind rotated_box_bounds rbb_checker u_rbb_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);
